[hw/rtl/tsm_pkg.sv]
// tsm_pkg: widths, reset values, register indexes and sequencer states
// of the tach speed meter, and a saturating increment. No dependencies.
`default_nettype none

package tsm_pkg;

  // time counters and smoothed speed
  localparam int TIME_BITS       = 24;
  localparam int SPEED_FRAC_BITS = 8;
  localparam int RPM_W           = 16;
  localparam int AVG_W           = RPM_W + SPEED_FRAC_BITS;

  // configuration register widths
  localparam int MINP_W  = 20;
  localparam int PPR_W   = 4;
  localparam int ALPHA_W = 8;
  localparam int TMO_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // divider: 60e6 fits 26 bits, divisor is ppr * period
  localparam int NUM_W = 26;
  localparam int DEN_W = PPR_W + TIME_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] RPM_NUM   = NUM_W'(60000000);
  localparam logic [RPM_W-1:0] RPM_LIMIT = {RPM_W{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // reset values
  localparam logic [MINP_W-1:0]  MINP_RST  = MINP_W'(12000);
  localparam logic [PPR_W-1:0]   PPR_RST   = PPR_W'(2);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(205);
  localparam logic [TMO_W-1:0]   TMO_RST   = TMO_W'(150000);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PERIOD = 2'd0,
    REG_PPR        = 2'd1,
    REG_ALPHA      = 2'd2,
    REG_TIMEOUT    = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MIX  = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

  // saturating increment of a time counter
  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    sat_inc = (v == TIME_MAX) ? v : v + TIME_BITS'(1);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tach_speed_meter_unit.sv]
// Fan tachometer: one word per microsecond tick, rpm from tach edge periods,
// exponential smoothing and timeout. Depends on tsm_pkg.
//
// Each accepted word is one microsecond tick and gives exactly one result
// word. A tick that does not close a valid period (no edge, a stall edge,
// or a timeout) goes straight to the output step. A tick whose edge closes
// a period longer than min_period_us passes through these steps: one to
// form the divisor pulses_per_rev * period, 26 steps of the restoring
// divider for 60000000 / divisor (one quotient bit per cycle), one for the
// smoothing multiply-add and one to hand the result to the output register.
// The input is stalled while a tick is in work; a finished result may wait
// in the output register while the next tick is taken. Configuration writes
// are taken while no tick is in work. pulses_per_rev of zero acts as one.
`default_nettype none

module tach_speed_meter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tick input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_tach_falling,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tsm_pkg::RPM_W-1:0]            out_speed_rpm,
  output logic                                 out_updated,
  output logic                                 out_stall_res,
  output logic                                 out_timed_out,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsm_pkg::*;

  // configuration registers
  logic [MINP_W-1:0]  min_period_r;
  logic [PPR_W-1:0]   ppr_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [TMO_W-1:0]   timeout_r;

  // tick state
  seq_state_t           state_r, state_nxt;
  logic [TIME_BITS-1:0] tse_r, tse_nxt;
  logic [TIME_BITS-1:0] tsu_r, tsu_nxt;
  logic [AVG_W-1:0]     avg_r, avg_nxt;
  logic                 stall_flag_r, stall_flag_nxt;

  // work registers of the current tick
  logic [TIME_BITS-1:0] period_r, period_nxt;
  logic                 upd_r, upd_nxt;
  logic                 tmo_r, tmo_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]     out_rpm_r, out_rpm_nxt;
  logic                 out_upd_r, out_upd_nxt;
  logic                 out_stl_r, out_stl_nxt;
  logic                 out_tmo_r, out_tmo_nxt;

  // combinational helpers
  logic                 in_take;
  logic                 out_free;
  logic [TIME_BITS-1:0] edge_cnt;
  logic [TIME_BITS-1:0] upd_cnt;
  logic [PPR_W-1:0]     ppr_eff;
  logic [DEN_W:0]       rem_sh;
  logic [RPM_W-1:0]     rpm_sat;
  logic [AVG_W-1:0]     sample;
  logic [ALPHA_W:0]     beta;
  logic [AVG_W+ALPHA_W:0] mix_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign edge_cnt = sat_inc(tse_r);
  assign upd_cnt  = sat_inc(tsu_r);
  assign ppr_eff  = (ppr_r == '0) ? PPR_W'(1) : ppr_r;

  // one restoring divide step: bring down the next numerator bit
  assign rem_sh = {rem_r, RPM_NUM[cnt_r]};

  // smoothing: alpha weights the old average, 256 - alpha the new sample
  assign rpm_sat = (quo_r > NUM_W'(RPM_LIMIT)) ? RPM_LIMIT : quo_r[RPM_W-1:0];
  assign sample  = {rpm_sat, {SPEED_FRAC_BITS{1'b0}}};
  assign beta    = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_r};
  assign mix_sum = (AVG_W+ALPHA_W+1)'(alpha_r) * (AVG_W+ALPHA_W+1)'(avg_r) +
                   (AVG_W+ALPHA_W+1)'(beta) * (AVG_W+ALPHA_W+1)'(sample);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    tse_nxt        = tse_r;
    tsu_nxt        = tsu_r;
    avg_nxt        = avg_r;
    stall_flag_nxt = stall_flag_r;
    period_nxt     = period_r;
    upd_nxt        = upd_r;
    tmo_nxt        = tmo_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rpm_nxt    = out_rpm_r;
    out_upd_nxt    = out_upd_r;
    out_stl_nxt    = out_stl_r;
    out_tmo_nxt    = out_tmo_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          upd_nxt    = 1'b0;
          tmo_nxt    = 1'b0;
          period_nxt = edge_cnt;
          tse_nxt    = in_tach_falling ? '0 : edge_cnt;
          tsu_nxt    = upd_cnt;
          state_nxt  = S_OUT;
          if (in_tach_falling && (edge_cnt > TIME_BITS'(min_period_r))) begin
            // valid period: counters restart, average waits for the divider
            upd_nxt        = 1'b1;
            stall_flag_nxt = 1'b0;
            tsu_nxt        = '0;
            state_nxt      = S_PREP;
          end else begin
            if (in_tach_falling) begin
              stall_flag_nxt = 1'b1;
            end
            if (upd_cnt >= timeout_r) begin
              avg_nxt = '0;
              tmo_nxt = 1'b1;
            end
          end
        end
      end
      S_PREP: begin
        den_nxt   = DEN_W'(ppr_eff) * DEN_W'(period_r);
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(NUM_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = S_MIX;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_MIX: begin
        avg_nxt   = mix_sum[AVG_W+ALPHA_W-1:ALPHA_W];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rpm_nxt   = avg_r[AVG_W-1:SPEED_FRAC_BITS];
          out_upd_nxt   = upd_r;
          out_stl_nxt   = stall_flag_r;
          out_tmo_nxt   = tmo_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tse_r        <= '0;
      tsu_r        <= '0;
      avg_r        <= '0;
      stall_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tse_r        <= tse_nxt;
      tsu_r        <= tsu_nxt;
      avg_r        <= avg_nxt;
      stall_flag_r <= stall_flag_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MINP_RST;
      ppr_r        <= PPR_RST;
      alpha_r      <= ALPHA_RST;
      timeout_r    <= TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_PERIOD: min_period_r <= cfg_data[MINP_W-1:0];
        REG_PPR:        ppr_r        <= cfg_data[PPR_W-1:0];
        REG_ALPHA:      alpha_r      <= cfg_data[ALPHA_W-1:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data[TMO_W-1:0];
        default:        ;
      endcase
    end
  end

  // work and output payload registers
  always_ff @(posedge clk) begin
    period_r  <= period_nxt;
    upd_r     <= upd_nxt;
    tmo_r     <= tmo_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    out_rpm_r <= out_rpm_nxt;
    out_upd_r <= out_upd_nxt;
    out_stl_r <= out_stl_nxt;
    out_tmo_r <= out_tmo_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_speed_rpm = out_rpm_r;
  assign out_updated   = out_upd_r;
  assign out_stall_res = out_stl_r;
  assign out_timed_out = out_tmo_r;

  // a timeout clears the average, so the reported speed is zero
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_speed_rpm == '0)
    else $error("timed out word carries nonzero speed");

  // an update never comes with a timeout or a stall flag in the same word
  a_upd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |-> !out_timed_out && !out_stall_res)
    else $error("updated word also flags timeout or stall");

  // divider always ends in the smoothing step
  a_div_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == '0 |=> state_r == S_MIX)
    else $error("divider did not hand over to smoothing");

endmodule

`default_nettype wire
